/* rtl/core/adts_frame_deframer_defines.svh */
// Assertion macros for the ADTS frame deframer.
// Included by the top level; expects signals named clk and rst_n in scope.
`ifndef ADTS_FRAME_DEFRAMER_DEFINES_SVH
`define ADTS_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ADF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ADF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/adf_pkg.sv */
// Shared types and constants of the ADTS frame deframer.
// No dependencies.
package adf_pkg;

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_TRUNC  = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;
  localparam logic [12:0] MIN_FRAME_LEN = 13'd7;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [1:0]  profile;
    logic [3:0]  rate_index;
    logic [12:0] frame_length;
    logic [1:0]  status;
  } adf_result_t;

  typedef struct packed {
    logic [1:0]  cnt;
    adf_result_t e0;
    adf_result_t e1;
  } adf_push_t;

endpackage

/* rtl/core/adf_front.sv */
// Front end of the ADTS frame deframer: sync hunt, header parsing and marking.
// Depends on adf_pkg; pushes zero, one or two results per request into the queue.
module adf_front import adf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_data,
  input  logic       space_ok,
  output adf_push_t  push
);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_FRAME = 2'd1;

  logic [1:0]  phase_r, phase_nxt;
  logic        held_r, held_nxt;
  logic [12:0] idx_r, idx_nxt;
  logic [12:0] len_r, len_nxt;
  logic [1:0]  prof_r, prof_nxt;
  logic [3:0]  rate_r, rate_nxt;

  logic        accept;
  logic [1:0]  prof_now;
  logic [3:0]  rate_now;
  logic [12:0] len_now;
  logic        last;
  logic [1:0]  st;
  logic        hdr_ok;

  assign in_ready = space_ok;
  assign accept   = in_valid && space_ok;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    prof_nxt  = prof_r;
    rate_nxt  = rate_r;
    push      = '0;
    prof_now  = prof_r;
    rate_now  = rate_r;
    len_now   = len_r;
    last      = 1'b0;
    st        = ST_NORMAL;
    hdr_ok    = idx_r >= 13'd2;

    if (idx_r == 13'd2) begin
      prof_now = in_data_byte[7:6];
      rate_now = in_data_byte[5:2];
    end
    case (idx_r)
      13'd3: len_now = {in_data_byte[1:0], 11'd0};
      13'd4: len_now = len_r | {2'd0, in_data_byte, 3'd0};
      13'd5: len_now = len_r | {10'd0, in_data_byte[7:5]};
      default: len_now = len_r;
    endcase
    if (idx_r == 13'd5 && len_now < MIN_FRAME_LEN) begin
      last = 1'b1;
      st   = ST_BADLEN;
    end else if (idx_r >= 13'd6 && ({1'b0, idx_r} + 14'd1) >= {1'b0, len_now}) begin
      last = 1'b1;
    end
    if (in_end_of_data && !last) begin
      last = 1'b1;
      st   = ST_TRUNC;
    end

    if (accept) begin
      case (phase_r)
        PH_HUNT: begin
          if (held_r && in_data_byte[7:4] == SYNC_NIBBLE) begin
            held_nxt = 1'b0;
            prof_nxt = '0;
            rate_nxt = '0;
            len_nxt  = '0;
            push.cnt = 2'd2;
            push.e0.data  = SYNC_BYTE;
            push.e0.first = 1'b1;
            push.e1.data  = in_data_byte;
            push.e1.last  = in_end_of_data;
            push.e1.status = in_end_of_data ? ST_TRUNC : ST_NORMAL;
            if (in_end_of_data) begin
              idx_nxt = '0;
            end else begin
              phase_nxt = PH_FRAME;
              idx_nxt   = 13'd2;
            end
          end else begin
            held_nxt = !in_end_of_data && in_data_byte == SYNC_BYTE;
          end
        end
        default: begin
          prof_nxt = prof_now;
          rate_nxt = rate_now;
          len_nxt  = len_now;
          push.cnt = 2'd1;
          push.e0.data         = in_data_byte;
          push.e0.last         = last;
          push.e0.profile      = hdr_ok ? prof_now : 2'd0;
          push.e0.rate_index   = hdr_ok ? rate_now : 4'd0;
          push.e0.frame_length = (idx_r >= 13'd5) ? len_now : 13'd0;
          push.e0.status       = st;
          if (last) begin
            phase_nxt = PH_HUNT;
            held_nxt  = 1'b0;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 13'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      held_r  <= 1'b0;
      idx_r   <= '0;
      len_r   <= '0;
      prof_r  <= '0;
      rate_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      prof_r  <= prof_nxt;
      rate_r  <= rate_nxt;
    end
  end

endmodule

/* rtl/core/adf_queue.sv */
// Result queue of the ADTS frame deframer: up to two writes and one read per cycle.
// Depends on adf_pkg; decouples the front end from the output channel.
module adf_queue import adf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  adf_push_t                  push,
  input  logic                       pop,
  output adf_result_t                head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  adf_result_t   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign head      = mem_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    case (push.cnt)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.e0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/core/adts_frame_deframer.sv */
// Top level of the ADTS frame deframer: front end, result queue and output channel.
// Depends on adf_pkg, adf_front, adf_queue and adts_frame_deframer_defines.svh.
//
// The block takes up to one stream byte per clock and passes through every
// ADTS frame it finds, header included, marking the first and last byte and
// attaching the profile, sampling-rate index, frame length and an end status.
// A result is queued and offered from its head. The confirming sync byte yields
// two results (the held 0xFF and itself), which the queue drains one per cycle
// while out_ready is high; input requests are taken whenever the queue of
// QUEUE_DEPTH entries has at least two free places, so with a ready output and
// a QUEUE_DEPTH of at least four the input runs at one byte per clock without
// pause. The output port sets the sustained rate at one result per clock.
`include "adts_frame_deframer_defines.svh"

module adts_frame_deframer import adf_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_frame_first,
  output logic        out_frame_last,
  output logic [1:0]  out_profile,
  output logic [3:0]  out_rate_index,
  output logic [12:0] out_frame_length,
  output logic [1:0]  out_status
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  adf_push_t     push;
  adf_result_t   head;
  logic [CW-1:0] q_count;
  logic          space_ok;
  logic          pop;

  assign space_ok  = q_count <= CW'(QUEUE_DEPTH - 2);
  assign out_valid = q_count != '0;
  assign pop       = out_valid && out_ready;

  adf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_end_of_data (in_end_of_data),
    .space_ok       (space_ok),
    .push           (push)
  );

  adf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  assign out_byte         = head.data;
  assign out_frame_first  = head.first;
  assign out_frame_last   = head.last;
  assign out_profile      = head.profile;
  assign out_rate_index   = head.rate_index;
  assign out_frame_length = head.frame_length;
  assign out_status       = head.status;

  `ADF_ASSERT_IMPL(a_first_is_sync, out_valid && out_frame_first, out_byte == SYNC_BYTE, "frame start is not a sync byte")
  `ADF_ASSERT_IMPL(a_status_on_last, out_valid && (out_status != ST_NORMAL), out_frame_last, "end status on a byte that does not end a frame")
  `ADF_ASSERT_IMPL(a_queue_bound, 1'b1, q_count <= CW'(QUEUE_DEPTH), "result queue overflow")
  `ADF_ASSERT_NEXT(a_pair_visible, in_valid && in_ready && (push.cnt == 2'd2), q_count >= CW'(2), "sync pair not queued")

endmodule

/* bench/tb_adts_frame_deframer.sv */
// Self-checking testbench for adts_frame_deframer: directed and random byte streams.
// Each accepted request is predicted in the bench and every output byte is compared.
// Depends on adf_pkg and the RTL of the deframer only.
module tb_adts_frame_deframer;
  import adf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
    logic       drain;
  } stream_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_data = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_frame_first;
  logic        out_frame_last;
  logic [1:0]  out_profile;
  logic [3:0]  out_rate_index;
  logic [12:0] out_frame_length;
  logic [1:0]  out_status;

  adts_frame_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_data   (in_end_of_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_frame_first  (out_frame_first),
    .out_frame_last   (out_frame_last),
    .out_profile      (out_profile),
    .out_rate_index   (out_rate_index),
    .out_frame_length (out_frame_length),
    .out_status       (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stream_req_t stream_q[$];
  adf_result_t expected_bytes[$];
  logic        drain_next = 1'b0;
  int          n_requests = 0;
  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_frames = 0;
  int          n_truncated = 0;
  int          n_badlen = 0;
  int          errors = 0;

  // Deframer state as seen by the bench.
  logic        in_frame = 1'b0;
  logic        sync_held = 1'b0;
  logic [12:0] frame_pos = 13'd0;
  logic [12:0] hdr_len = 13'd0;
  logic [1:0]  hdr_profile = 2'd0;
  logic [3:0]  hdr_rate = 4'd0;

  function automatic adf_result_t make_result(input logic [7:0] b, input logic first,
                                              input logic last, input logic [1:0] prof,
                                              input logic [3:0] rate, input logic [12:0] len,
                                              input logic [1:0] st);
    adf_result_t r;
    r.data = b;
    r.first = first;
    r.last = last;
    r.profile = prof;
    r.rate_index = rate;
    r.frame_length = len;
    r.status = st;
    return r;
  endfunction

  task automatic predict_bytes(input logic [7:0] b, input logic eod);
    logic        last;
    logic [1:0]  st;
    logic [12:0] len_out;
    int          pos;
    if (!in_frame) begin
      if (sync_held && b[7:4] == SYNC_NIBBLE) begin
        sync_held = 1'b0;
        hdr_profile = 2'd0;
        hdr_rate = 4'd0;
        hdr_len = 13'd0;
        expected_bytes.push_back(make_result(SYNC_BYTE, 1'b1, 1'b0, 2'd0, 4'd0, 13'd0,
                                             ST_NORMAL));
        expected_bytes.push_back(make_result(b, 1'b0, eod, 2'd0, 4'd0, 13'd0,
                                             eod ? ST_TRUNC : ST_NORMAL));
        if (eod) begin
          frame_pos = 13'd0;
        end else begin
          in_frame = 1'b1;
          frame_pos = 13'd2;
        end
      end else begin
        sync_held = !eod && b == SYNC_BYTE;
      end
    end else begin
      pos = frame_pos;
      last = 1'b0;
      st = ST_NORMAL;
      len_out = 13'd0;
      case (pos)
        2: begin
          hdr_profile = b[7:6];
          hdr_rate = b[5:2];
        end
        3: hdr_len = {b[1:0], 11'd0};
        4: hdr_len = hdr_len | {2'b00, b, 3'b000};
        5: hdr_len = hdr_len | {10'd0, b[7:5]};
        default: ;
      endcase
      if (pos >= 5) begin
        len_out = hdr_len;
        if (pos == 5 && hdr_len < MIN_FRAME_LEN) begin
          last = 1'b1;
          st = ST_BADLEN;
        end else if (pos >= 6 && pos + 1 >= int'(hdr_len)) begin
          last = 1'b1;
        end
      end
      if (eod && !last) begin
        last = 1'b1;
        st = ST_TRUNC;
      end
      expected_bytes.push_back(make_result(b, 1'b0, last, hdr_profile, hdr_rate, len_out, st));
      if (last) begin
        in_frame = 1'b0;
        sync_held = 1'b0;
        frame_pos = 13'd0;
      end else begin
        frame_pos = frame_pos + 13'd1;
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eod);
    stream_req_t r;
    r.data = b;
    r.eod = eod;
    r.drain = drain_next;
    drain_next = 1'b0;
    stream_q.push_back(r);
    n_requests++;
  endtask

  // Sends frame bytes 0 to stop_at; the byte at stop_at carries the given end-of-data flag.
  task automatic push_frame(input logic [12:0] len, input int stop_at, input logic eod,
                            input logic [7:0] sync2, input logic [7:0] hdr2);
    logic [7:0] b;
    for (int i = 0; i <= stop_at; i++) begin
      case (i)
        0: b = SYNC_BYTE;
        1: b = sync2;
        2: b = hdr2;
        3: b = {6'($urandom), len[12:11]};
        4: b = len[10:3];
        5: b = {len[2:0], 5'($urandom)};
        default: b = 8'($urandom);
      endcase
      push_byte(b, (i == stop_at) ? eod : 1'b0);
    end
  endtask

  initial begin : stimulus
    logic [12:0] len;
    int          kind;
    int          natural_end;
    int          stop_at;
    logic        eod;
    logic        long_len;
    // Directed part: broken sync, repeated sync bytes, status cases at the extremes.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_frame(13'd7, 6, 1'b1, 8'hFF, 8'hFF);
    push_frame(13'd0, 5, 1'b1, 8'hF0, 8'h00);
    push_frame(13'd6, 5, 1'b0, 8'hFA, 8'h5C);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hF0, 1'b0);
    push_frame(13'd7, 1, 1'b1, 8'hF0, 8'h00);
    push_frame(13'h1FFF, 2, 1'b1, 8'hF5, 8'h80);

    drain_next = 1'b1;
    while (n_requests < 1540) begin
      if ($urandom_range(39, 0) == 0) drain_next = 1'b1;
      kind = $urandom_range(9, 0);
      if (kind < 7) begin
        kind = $urandom_range(19, 0);
        long_len = 1'b0;
        if (kind < 2) begin
          len = 13'($urandom_range(6, 0));
        end else if (kind < 5) begin
          len = 13'($urandom_range(8191, 41));
          long_len = 1'b1;
        end else begin
          len = 13'($urandom_range(40, 7));
        end
        natural_end = (len < MIN_FRAME_LEN) ? 5 : int'(len) - 1;
        if (long_len) begin
          stop_at = $urandom_range(30, 1);
          eod = 1'b1;
        end else if ($urandom_range(9, 0) == 0) begin
          stop_at = $urandom_range(natural_end, 1);
          eod = 1'b1;
        end else begin
          stop_at = natural_end;
          eod = 1'b0;
        end
        push_frame(len, stop_at, eod, {SYNC_NIBBLE, 4'($urandom)}, 8'($urandom));
      end else begin
        repeat ($urandom_range(6, 1))
          push_byte(($urandom_range(3, 0) == 0) ? SYNC_BYTE : 8'($urandom),
                    $urandom_range(7, 0) == 0);
      end
    end

    wait (rst_n);
    while (n_accepted != n_requests) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Streamed %0d bytes and checked %0d output bytes in %0d frames.",
             n_accepted, n_checked, n_frames);
    $display("Frames cut short by end of data: %0d; frames with a bad length: %0d.",
             n_truncated, n_badlen);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Sender: bursts of random length with random gaps; a marked request waits for a drain.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drive
    stream_req_t r;
    logic        nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_bytes(in_data_byte, in_end_of_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (stream_q.size() != 0 &&
                     !(stream_q[0].drain && expected_bytes.size() != 0)) begin
          r = stream_q.pop_front();
          in_data_byte <= r.data;
          in_end_of_data <= r.eod;
          nv = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_left--;
          end
        end
        in_valid <= nv;
      end
    end
  end

  // Receiver: rotating stall pattern, occasional long hold-offs.
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [5:0]  rx_tick = 6'd0;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk) begin : receive
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left == 0 && !long_hold_done && n_checked >= 300) begin
        hold_left = 80;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && $urandom_range(799, 0) == 0) begin
        hold_left = $urandom_range(50, 20);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (rx_tick == 6'd0)
          rx_pattern = ($urandom_range(3, 0) == 0) ? 16'hFFFF : (16'($urandom) | 16'h8001);
        out_ready <= rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        rx_tick = rx_tick + 6'd1;
      end
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    adf_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("Output byte 0x%02h arrived with nothing expected.", out_byte);
        errors++;
      end else begin
        e = expected_bytes.pop_front();
        check_field("out_byte", e.data, out_byte);
        check_field("frame_first", e.first, out_frame_first);
        check_field("frame_last", e.last, out_frame_last);
        check_field("profile", e.profile, out_profile);
        check_field("rate_index", e.rate_index, out_rate_index);
        check_field("frame_length", e.frame_length, out_frame_length);
        check_field("status", e.status, out_status);
      end
      n_checked++;
      if (out_frame_first) n_frames++;
      if (out_frame_last && out_status == ST_TRUNC) n_truncated++;
      if (out_frame_last && out_status == ST_BADLEN) n_badlen++;
    end
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/adf_pkg.sv
rtl/core/adf_front.sv
rtl/core/adf_queue.sv
rtl/core/adts_frame_deframer.sv
bench/tb_adts_frame_deframer.sv
